// File: rtl/tick_slip_monitor_unit_assert.svh
// Assertion macros for the checker file of this block.
`ifndef TICK_SLIP_MONITOR_UNIT_ASSERT_SVH
`define TICK_SLIP_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TSM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tick slip monitor check failed");

// Next-cycle implication, disabled during reset.
`define TSM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tick slip monitor check failed");

`endif

// File: rtl/tsm_pkg.sv
package tsm_pkg;

    localparam int RING_DEPTH_DEF   = 160;
    localparam int SETTLE_TICKS_DEF = 2;
    localparam int NOTE_GAP_MS_DEF  = 1000;

    localparam logic [7:0]  RUN_STATE        = 8'd2;
    localparam logic [31:0] LOW_LIMIT_MS     = 32'd100;
    localparam logic [31:0] DEFAULT_BCAST_MS = 32'd30000;
    localparam logic [30:0] MAX31            = '1;
    localparam logic [47:0] MAX48            = '1;

    localparam logic [1:0] REG_WINDOW    = 2'd0;
    localparam logic [1:0] REG_NOTIFY    = 2'd1;
    localparam logic [1:0] REG_BC_THRESH = 2'd2;
    localparam logic [1:0] REG_BC_IVAL   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_BCAST,
        ST_DONE
    } tsm_state_t;

    function automatic logic [47:0] sat48_add(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? MAX48 : s[47:0];
    endfunction

endpackage

// File: rtl/tsm_ring.sv
module tsm_ring import tsm_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [30:0]      wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [30:0]      rd_data
);

    logic [30:0] mem [RING_DEPTH];
    logic [30:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/tsm_div.sv
// Restoring divider, one quotient bit per cycle.
module tsm_div import tsm_pkg::*; #(
    parameter int DVD_W = 43,
    parameter int DVS_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;

    always_comb begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        if (start) begin
            cnt_next  = CNT_W'(DVD_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/tick_slip_monitor_unit.sv
// A check item or an unsampled tick goes from ST_IDLE straight to ST_DONE, where its result
// is registered once the output is free. A settled tick first passes ST_SUM, one ring read
// per cycle into the accumulator over the window, then the serial divider in ST_DIV, then
// ST_BCAST. One item at a time; s_tready is high only when no item is at work, so a new item
// is accepted only once the last result is registered, which waits while the output stalls.
// aresetn is synchronous, active low: registers take their reset values, ring is unwritten.
module tick_slip_monitor_unit import tsm_pkg::*; #(
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int SETTLE_TICKS = SETTLE_TICKS_DEF,
    parameter int NOTE_GAP_MS  = NOTE_GAP_MS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // server_frame, server_state, game_time, real_time, now_ms
    input  logic [135:0] s_tdata,
    // func
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // last_lost, avg_lost_x16, lost_total, high_clamp_count, low_clamp_count,
    // low_check_count, gained_total, worst_gain, note_high, note_broadcast,
    // note_low, sample_taken, zero pad
    output logic [343:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int ACC_W = 31 + CNT_W;
    localparam int DVD_W = ACC_W + 4;

    logic [7:0]  window_reg;
    logic [15:0] notify_reg;
    logic [34:0] bc_thresh_reg;
    logic [31:0] bc_ival_reg;

    logic        cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[4:3])
            REG_WINDOW:    prdata = {56'd0, window_reg};
            REG_NOTIFY:    prdata = {48'd0, notify_reg};
            REG_BC_THRESH: prdata = {29'd0, bc_thresh_reg};
            REG_BC_IVAL:   prdata = {32'd0, bc_ival_reg};
            default:       prdata = '0;
        endcase
    end

    logic        func_in;
    logic [31:0] frame_in, gt_in, rt_in, now_in;
    logic [7:0]  state_in;
    assign func_in  = s_tuser[0];
    assign frame_in = s_tdata[31:0];
    assign state_in = s_tdata[39:32];
    assign gt_in    = s_tdata[71:40];
    assign rt_in    = s_tdata[103:72];
    assign now_in   = s_tdata[135:104];

    tsm_state_t state_reg, state_next;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [31:0]      prev_reg, prev_next;
    logic [1:0]       settle_reg, settle_next;
    logic [30:0]      latest_reg, latest_next;
    logic [34:0]      mean_reg, mean_next;
    logic [47:0]      lost_tot_reg, lost_tot_next;
    logic [47:0]      high_cnt_reg, high_cnt_next;
    logic [47:0]      low_cnt_reg, low_cnt_next;
    logic [47:0]      chk_cnt_reg, chk_cnt_next;
    logic [47:0]      gain_tot_reg, gain_tot_next;
    logic [30:0]      max_gain_reg, max_gain_next;
    logic [31:0]      hn_time_reg, hn_time_next;
    logic             hn_done_reg, hn_done_next;
    logic [31:0]      ln_time_reg, ln_time_next;
    logic             ln_done_reg, ln_done_next;
    logic [31:0]      bc_time_reg, bc_time_next;
    logic             bc_done_reg, bc_done_next;

    logic [31:0]      now_reg, now_next;
    logic             lost_pos_reg, lost_pos_next;
    logic             f_high_reg, f_high_next;
    logic             f_bc_reg, f_bc_next;
    logic             f_low_reg, f_low_next;
    logic             f_taken_reg, f_taken_next;

    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             pend_reg, pend_next;
    logic [ACC_W-1:0] acc_reg, acc_next;

    logic [343:0]     out_reg, out_next;
    logic             mv_reg, mv_next;

    logic             ring_we, ring_re, div_start, div_done;
    logic [30:0]      ring_rdata, lost_val, gain_val;
    logic [DVD_W-1:0] quotient;
    logic [31:0]      diff_rg, diff_gr, gain_raw, w32, fill32, n32, ival;
    logic             cont;

    tsm_ring #(.RING_DEPTH(RING_DEPTH), .IDX_W(IDX_W)) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_we),
        .wr_addr (head_reg),
        .wr_data (lost_val),
        .rd_en   (ring_re),
        .rd_addr (ptr_reg),
        .rd_data (ring_rdata)
    );

    tsm_div #(.DVD_W(DVD_W), .DVS_W(CNT_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({acc_reg, 4'b0000}),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        diff_rg  = rt_in - gt_in;
        diff_gr  = gt_in - rt_in;
        gain_raw = diff_gr - LOW_LIMIT_MS;
        lost_val = (gt_in < rt_in) ? (diff_rg[31] ? MAX31 : diff_rg[30:0]) : 31'd0;
        gain_val = gain_raw[31] ? MAX31 : gain_raw[30:0];
        cont     = (state_in == RUN_STATE) && (frame_in == prev_reg + 32'd1);
        w32      = {24'd0, window_reg};
        if (w32 == 32'd0) begin
            w32 = 32'd1;
        end else if (w32 > 32'(RING_DEPTH)) begin
            w32 = 32'(RING_DEPTH);
        end
        fill32 = 32'(fill_reg);
        if (fill_reg < CNT_W'(RING_DEPTH)) begin
            fill32 = fill32 + 32'd1;
        end
        n32  = (w32 < fill32) ? w32 : fill32;
        ival = (bc_ival_reg == 32'd0) ? DEFAULT_BCAST_MS : bc_ival_reg;
    end

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        prev_next     = prev_reg;
        settle_next   = settle_reg;
        latest_next   = latest_reg;
        mean_next     = mean_reg;
        lost_tot_next = lost_tot_reg;
        high_cnt_next = high_cnt_reg;
        low_cnt_next  = low_cnt_reg;
        chk_cnt_next  = chk_cnt_reg;
        gain_tot_next = gain_tot_reg;
        max_gain_next = max_gain_reg;
        hn_time_next  = hn_time_reg;
        hn_done_next  = hn_done_reg;
        ln_time_next  = ln_time_reg;
        ln_done_next  = ln_done_reg;
        bc_time_next  = bc_time_reg;
        bc_done_next  = bc_done_reg;
        now_next      = now_reg;
        lost_pos_next = lost_pos_reg;
        f_high_next   = f_high_reg;
        f_bc_next     = f_bc_reg;
        f_low_next    = f_low_reg;
        f_taken_next  = f_taken_reg;
        n_next        = n_reg;
        issue_next    = issue_reg;
        ptr_next      = ptr_reg;
        pend_next     = 1'b0;
        acc_next      = acc_reg;
        out_next      = out_reg;
        mv_next       = mv_reg;
        ring_we       = 1'b0;
        ring_re       = 1'b0;
        div_start     = 1'b0;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    f_high_next  = 1'b0;
                    f_bc_next    = 1'b0;
                    f_low_next   = 1'b0;
                    f_taken_next = 1'b0;
                    now_next     = now_in;
                    state_next   = ST_DONE;
                    if (!func_in) begin
                        prev_next = frame_in;
                        if (!cont) begin
                            settle_next = 2'(SETTLE_TICKS);
                            head_next   = '0;
                            fill_next   = '0;
                            latest_next = '0;
                            mean_next   = '0;
                        end else if (settle_reg != 2'd0) begin
                            settle_next = settle_reg - 2'd1;
                        end else begin
                            f_taken_next = 1'b1;
                            ring_we      = 1'b1;
                            head_next    = (head_reg == IDX_W'(RING_DEPTH - 1)) ? '0
                                           : head_reg + 1'b1;
                            fill_next    = CNT_W'(fill32);
                            latest_next  = lost_val;
                            lost_pos_next = (lost_val != 31'd0);
                            if (lost_val != 31'd0) begin
                                high_cnt_next = sat48_add(high_cnt_reg, 48'd1);
                                lost_tot_next = sat48_add(lost_tot_reg, {17'd0, lost_val});
                                if (notify_reg != 16'd0 && lost_val >= {15'd0, notify_reg}
                                    && !(hn_done_reg &&
                                         (now_in - hn_time_reg) < 32'(NOTE_GAP_MS))) begin
                                    hn_done_next = 1'b1;
                                    hn_time_next = now_in;
                                    f_high_next  = 1'b1;
                                end
                            end
                            // Walk from the newest sample backward.
                            n_next     = CNT_W'(n32);
                            issue_next = CNT_W'(n32);
                            ptr_next   = head_reg;
                            acc_next   = '0;
                            state_next = ST_SUM;
                        end
                    end else if (state_in == RUN_STATE && settle_reg == 2'd0) begin
                        chk_cnt_next = sat48_add(chk_cnt_reg, 48'd1);
                        if (rt_in < gt_in && diff_gr > LOW_LIMIT_MS) begin
                            low_cnt_next  = sat48_add(low_cnt_reg, 48'd1);
                            gain_tot_next = sat48_add(gain_tot_reg, {17'd0, gain_val});
                            if (gain_val > max_gain_reg) begin
                                max_gain_next = gain_val;
                            end
                            if (!ln_done_reg ||
                                (now_in - ln_time_reg) >= 32'(NOTE_GAP_MS)) begin
                                ln_done_next = 1'b1;
                                ln_time_next = now_in;
                                f_low_next   = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_SUM: begin
                if (issue_reg != '0) begin
                    ring_re    = 1'b1;
                    pend_next  = 1'b1;
                    issue_next = issue_reg - 1'b1;
                    ptr_next   = (ptr_reg == '0) ? IDX_W'(RING_DEPTH - 1) : ptr_reg - 1'b1;
                end
                if (pend_reg) begin
                    acc_next = acc_reg + ACC_W'(ring_rdata);
                end
                if (issue_reg == '0 && !pend_reg) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    mean_next  = quotient[34:0];
                    state_next = ST_BCAST;
                end
            end
            ST_BCAST: begin
                if (lost_pos_reg && bc_thresh_reg != 35'd0 && mean_reg >= bc_thresh_reg
                    && !(bc_done_reg && (now_reg - bc_time_reg) < ival)) begin
                    bc_done_next = 1'b1;
                    bc_time_next = now_reg;
                    f_bc_next    = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!mv_reg || m_tready) begin
                    out_next = {3'd0, f_taken_reg, f_low_reg, f_bc_reg, f_high_reg,
                                max_gain_reg, gain_tot_reg, chk_cnt_reg, low_cnt_reg,
                                high_cnt_reg, lost_tot_reg, mean_reg, latest_reg};
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= 8'd20;
            notify_reg    <= 16'd5;
            bc_thresh_reg <= '0;
            bc_ival_reg   <= 32'd30000;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                REG_WINDOW:    window_reg    <= pwdata[7:0];
                REG_NOTIFY:    notify_reg    <= pwdata[15:0];
                REG_BC_THRESH: bc_thresh_reg <= pwdata[34:0];
                REG_BC_IVAL:   bc_ival_reg   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            fill_reg     <= '0;
            prev_reg     <= '1;
            settle_reg   <= 2'(SETTLE_TICKS);
            latest_reg   <= '0;
            mean_reg     <= '0;
            lost_tot_reg <= '0;
            high_cnt_reg <= '0;
            low_cnt_reg  <= '0;
            chk_cnt_reg  <= '0;
            gain_tot_reg <= '0;
            max_gain_reg <= '0;
            hn_time_reg  <= '0;
            hn_done_reg  <= 1'b0;
            ln_time_reg  <= '0;
            ln_done_reg  <= 1'b0;
            bc_time_reg  <= '0;
            bc_done_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            mv_reg       <= 1'b0;
            issue_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            prev_reg     <= prev_next;
            settle_reg   <= settle_next;
            latest_reg   <= latest_next;
            mean_reg     <= mean_next;
            lost_tot_reg <= lost_tot_next;
            high_cnt_reg <= high_cnt_next;
            low_cnt_reg  <= low_cnt_next;
            chk_cnt_reg  <= chk_cnt_next;
            gain_tot_reg <= gain_tot_next;
            max_gain_reg <= max_gain_next;
            hn_time_reg  <= hn_time_next;
            hn_done_reg  <= hn_done_next;
            ln_time_reg  <= ln_time_next;
            ln_done_reg  <= ln_done_next;
            bc_time_reg  <= bc_time_next;
            bc_done_reg  <= bc_done_next;
            pend_reg     <= pend_next;
            mv_reg       <= mv_next;
            issue_reg    <= issue_next;
        end
        now_reg      <= now_next;
        lost_pos_reg <= lost_pos_next;
        f_high_reg   <= f_high_next;
        f_bc_reg     <= f_bc_next;
        f_low_reg    <= f_low_next;
        f_taken_reg  <= f_taken_next;
        n_reg        <= n_next;
        ptr_reg      <= ptr_next;
        acc_reg      <= acc_next;
        out_reg      <= out_next;
    end

endmodule

// File: rtl/tsm_checker.sv
`include "tick_slip_monitor_unit_assert.svh"

module tsm_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [343:0] m_tdata
);

    // A result waiting for the sink stays offered.
    `TSM_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // The block works on one item at a time.
    `TSM_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // Both tick notices only come from a settled sample.
    `TSM_ASSERT_IMP(a_notes_need_sample, aclk, aresetn,
                    m_tvalid && (m_tdata[337] || m_tdata[338]), m_tdata[340])
    // A high-clamp notice means time was actually lost on that tick.
    `TSM_ASSERT_IMP(a_high_needs_loss, aclk, aresetn,
                    m_tvalid && m_tdata[337], m_tdata[30:0] != 31'd0)

endmodule

bind tick_slip_monitor_unit tsm_checker u_tsm_checker (.*);
